FILE: rtl/core/sicc_pkg.sv
// Shared types, constants and CRC column table for the section image CRC checker.
`timescale 1ns / 1ps
`default_nettype none

package sicc_pkg;

    localparam int unsigned MAX_SECTIONS      = 64;
    localparam int unsigned MAX_SECTION_WORDS = 1024;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned STAT_W = 3;
    localparam int unsigned FAIL_W = 6;
    localparam int unsigned IDX_W  = $clog2(MAX_SECTION_WORDS + 1);
    localparam int unsigned CNT_W  = $clog2(MAX_SECTIONS + 1);

    localparam logic [WORD_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [WORD_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    // Word position of the header CRC inside a section
    localparam logic [IDX_W-1:0] HDR_CRC_POS = IDX_W'(2);
    // Shortest legal section is four words: data CRC may not come before this
    localparam logic [IDX_W-1:0] MIN_END_POS = IDX_W'(3);

    localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
    localparam logic [STAT_W-1:0] ST_HDR    = 3'd1;
    localparam logic [STAT_W-1:0] ST_DATA   = 3'd2;
    localparam logic [STAT_W-1:0] ST_SUM    = 3'd3;
    localparam logic [STAT_W-1:0] ST_FORMAT = 3'd4;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              section_end;
        logic              image_end;
    } in_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [WORD_W-1:0] actual_sum;
        logic [FAIL_W-1:0] failing_section;
    } out_t;

    // Column i holds the 32-shift CRC of a lone set bit i; the update is linear
    function automatic logic [WORD_W-1:0][WORD_W-1:0] crc_cols_f();
        logic [WORD_W-1:0][WORD_W-1:0] cols;
        logic [WORD_W-1:0]             c;
        for (int i = 0; i < WORD_W; i++)
        begin
            c = WORD_W'(1) << i;
            for (int b = 0; b < WORD_W; b++)
            begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            cols[i] = c;
        end
        return cols;
    endfunction

    localparam logic [WORD_W-1:0][WORD_W-1:0] CRC_COLS = crc_cols_f();

endpackage

`default_nettype wire

FILE: rtl/core/sicc_crc_word.sv
// One-word CRC-32 (reflected) update as a flat XOR network.
`timescale 1ns / 1ps
`default_nettype none

module sicc_crc_word (
    input  wire logic [sicc_pkg::WORD_W-1:0] crc_in,
    input  wire logic [sicc_pkg::WORD_W-1:0] word_in,
    output      logic [sicc_pkg::WORD_W-1:0] crc_out
);

    logic [sicc_pkg::WORD_W-1:0] mix;

    assign mix = crc_in ^ word_in;

    always_comb
    begin
        crc_out = '0;
        for (int i = 0; i < sicc_pkg::WORD_W; i++)
        begin
            if (mix[i])
            begin
                crc_out = crc_out ^ sicc_pkg::CRC_COLS[i];
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/section_image_crc_checker_core.sv
// Top level of the section image CRC checker.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------
//   in      | input     | in_valid / in_ready  | in_data  (word, section/image end)
//   out     | output    | out_valid/ out_ready | out_data (status, sum, section)
//   cfg     | input     | cfg_valid/ cfg_ready | cfg_data (expected_sum)
//
// One word per cycle sustained while no image-end word waits on a held result.
// A word is registered in the input register on acceptance and checked there
// by the word-wide CRC XOR network; the image result enters the output register
// as that word leaves the input register. A word flagged as image end waits
// there only while a previous result is still held; other words never wait.
// Reset clears the image state and sets expected_sum to zero; cfg is always ready.
`timescale 1ns / 1ps
`default_nettype none

module section_image_crc_checker_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output      logic                        in_ready,
    input  wire sicc_pkg::in_t               in_data,
    output      logic                        out_valid,
    input  wire logic                        out_ready,
    output      sicc_pkg::out_t              out_data,
    input  wire logic                        cfg_valid,
    output      logic                        cfg_ready,
    input  wire logic [sicc_pkg::WORD_W-1:0] cfg_data
);

    localparam int unsigned EXT_W = sicc_pkg::CNT_W + sicc_pkg::FAIL_W;

    logic                          s1_valid_reg;
    sicc_pkg::in_t                 s1_data_reg;
    logic                          s1_advance;

    logic [sicc_pkg::WORD_W-1:0]   expected_reg;
    logic [sicc_pkg::WORD_W-1:0]   crc_reg,  crc_next;
    logic [sicc_pkg::IDX_W-1:0]    idx_reg,  idx_next;
    logic [sicc_pkg::WORD_W-1:0]   sum_reg,  sum_next;
    logic [sicc_pkg::CNT_W-1:0]    cnt_reg,  cnt_next;
    logic [sicc_pkg::STAT_W-1:0]   err_reg,  err_next;

    logic                          out_valid_reg, out_valid_next;
    sicc_pkg::out_t                out_data_reg,  out_data_next;

    logic [sicc_pkg::WORD_W-1:0]   crc_upd;
    logic [sicc_pkg::WORD_W-1:0]   crc_fin;
    logic                          crc_match;
    logic [sicc_pkg::WORD_W-1:0]   sum_add;
    logic [sicc_pkg::STAT_W-1:0]   status_w;
    logic [sicc_pkg::CNT_W-1:0]    sect_w;
    logic [EXT_W-1:0]              sect_ext;

    sicc_crc_word u_crc (
        .crc_in  (crc_reg),
        .word_in (s1_data_reg.word),
        .crc_out (crc_upd)
    );

    assign crc_fin   = ~crc_reg;
    assign crc_match = (crc_fin == s1_data_reg.word);
    assign sum_add   = sum_reg + crc_fin;

    // Hold an image-end word while the previous result is still unclaimed
    assign s1_advance = s1_valid_reg &&
                        (!s1_data_reg.image_end || !out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;
    assign cfg_ready  = 1'b1;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    always_comb
    begin
        crc_next       = crc_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        cnt_next       = cnt_reg;
        err_next       = err_reg;
        status_w       = err_reg;
        sect_w         = cnt_reg;
        sect_ext       = '0;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (s1_advance)
        begin
            if (err_reg == sicc_pkg::ST_OK)
            begin
                if (cnt_reg >= sicc_pkg::CNT_W'(sicc_pkg::MAX_SECTIONS) ||
                    idx_reg >= sicc_pkg::IDX_W'(sicc_pkg::MAX_SECTION_WORDS))
                begin
                    err_next = sicc_pkg::ST_FORMAT;
                end
                else if (s1_data_reg.section_end)
                begin
                    if (idx_reg < sicc_pkg::MIN_END_POS)
                    begin
                        err_next = sicc_pkg::ST_FORMAT;
                    end
                    else if (!crc_match)
                    begin
                        err_next = sicc_pkg::ST_DATA;
                    end
                    else
                    begin
                        sum_next = sum_add;
                        crc_next = sicc_pkg::CRC_INIT;
                        idx_next = '0;
                        cnt_next = cnt_reg + sicc_pkg::CNT_W'(1);
                    end
                end
                else if (s1_data_reg.image_end)
                begin
                    err_next = sicc_pkg::ST_FORMAT;
                end
                else if (idx_reg == sicc_pkg::HDR_CRC_POS)
                begin
                    if (!crc_match)
                    begin
                        err_next = sicc_pkg::ST_HDR;
                    end
                    else
                    begin
                        sum_next = sum_add;
                        crc_next = sicc_pkg::CRC_INIT;
                        idx_next = idx_reg + sicc_pkg::IDX_W'(1);
                    end
                end
                else
                begin
                    crc_next = crc_upd;
                    idx_next = idx_reg + sicc_pkg::IDX_W'(1);
                end
            end

            if (s1_data_reg.image_end)
            begin
                status_w = err_next;
                if (err_next == sicc_pkg::ST_OK && sum_next != expected_reg)
                begin
                    status_w = sicc_pkg::ST_SUM;
                end
                if (status_w == sicc_pkg::ST_OK || status_w == sicc_pkg::ST_SUM)
                begin
                    sect_w = cnt_next - sicc_pkg::CNT_W'(1);
                end
                else
                begin
                    sect_w = cnt_next;
                end
                sect_ext = EXT_W'(sect_w);

                out_valid_next                = 1'b1;
                out_data_next.status          = status_w;
                out_data_next.actual_sum      = sum_next;
                out_data_next.failing_section = sect_ext[sicc_pkg::FAIL_W-1:0];

                // Drop all image state for the next image
                crc_next = sicc_pkg::CRC_INIT;
                idx_next = '0;
                sum_next = '0;
                cnt_next = '0;
                err_next = sicc_pkg::ST_OK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            expected_reg  <= '0;
            crc_reg       <= sicc_pkg::CRC_INIT;
            idx_reg       <= '0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            err_reg       <= sicc_pkg::ST_OK;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                expected_reg <= cfg_data;
            end
            crc_reg <= crc_next;
            idx_reg <= idx_next;
            sum_reg <= sum_next;
            cnt_reg <= cnt_next;
            err_reg <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg <= in_data;
        end
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire

FILE: rtl/core/sicc_checker.sv
// Port-level assertions for the section image CRC checker, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module sicc_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_ready,
    input wire sicc_pkg::in_t               in_data,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire sicc_pkg::out_t              out_data,
    input wire logic                        cfg_valid,
    input wire logic                        cfg_ready,
    input wire logic [sicc_pkg::WORD_W-1:0] cfg_data
);

    // A stalled result keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.status == sicc_pkg::ST_OK   ||
                       out_data.status == sicc_pkg::ST_HDR  ||
                       out_data.status == sicc_pkg::ST_DATA ||
                       out_data.status == sicc_pkg::ST_SUM  ||
                       out_data.status == sicc_pkg::ST_FORMAT))
        else $error("status code out of range");

    // A fresh result follows an accepted image-end word
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready && in_data.image_end, 2))
        else $error("result without an image-end request");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result valid during reset");

endmodule

bind section_image_crc_checker_core sicc_checker u_sicc_checker (.*);

`default_nettype wire

FILE: bench/sicc_image_scoreboard.sv
// CRC helpers for the bench and the scoreboard that predicts and checks every image result.
`timescale 1ns / 1ps

package sicc_bench_pkg;

    import sicc_pkg::*;

    function automatic logic [WORD_W-1:0] crc_advance(input logic [WORD_W-1:0] crc,
                                                      input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] c;
        int                b;
        c = crc ^ w;
        for (b = 0; b < WORD_W; b++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Undo the shifts of crc_advance: a set top bit means the polynomial went in
    function automatic logic [WORD_W-1:0] crc_rewind(input logic [WORD_W-1:0] crc);
        logic [WORD_W-1:0] c;
        int                b;
        c = crc;
        for (b = 0; b < WORD_W; b++)
        begin
            c = c[WORD_W-1] ? (((c ^ CRC_POLY) << 1) | WORD_W'(1)) : (c << 1);
        end
        return c;
    endfunction

endpackage

module sicc_image_scoreboard (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_ready,
    input  sicc_pkg::in_t               in_data,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  sicc_pkg::out_t              out_data,
    input  logic                        cfg_valid,
    input  logic                        cfg_ready,
    input  logic [sicc_pkg::WORD_W-1:0] cfg_data,
    output int                          fail_count,
    output int                          results_owed,
    output int                          results_seen
);

    import sicc_pkg::*;
    import sicc_bench_pkg::*;

    logic [WORD_W-1:0] sum_target;
    logic [WORD_W-1:0] crc_run;
    logic [WORD_W-1:0] sum_run;
    int unsigned       pos_in_section;
    int unsigned       sections_done;
    logic [STAT_W-1:0] err_latched;
    out_t              image_results[$];

    initial
    begin
        fail_count   = 0;
        results_seen = 0;
        results_owed = 0;
    end

    task automatic report_mismatch(input string what, input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        if (fail_count < 40)
            $display("%0t ns: %s mismatch, got %h, want %h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic clear_image_state();
        crc_run        = CRC_INIT;
        sum_run        = '0;
        pos_in_section = 0;
        sections_done  = 0;
        err_latched    = ST_OK;
    endtask

    task automatic absorb_word(input in_t item);
        if (sections_done >= MAX_SECTIONS || pos_in_section >= MAX_SECTION_WORDS)
            err_latched = ST_FORMAT;
        else if (item.section_end)
        begin
            if (pos_in_section < MIN_END_POS)
                err_latched = ST_FORMAT;
            else if (~crc_run != item.word)
                err_latched = ST_DATA;
            else
            begin
                sum_run        = sum_run + ~crc_run;
                crc_run        = CRC_INIT;
                pos_in_section = 0;
                sections_done++;
            end
        end
        else if (item.image_end)
            err_latched = ST_FORMAT;
        else if (pos_in_section == HDR_CRC_POS)
        begin
            if (~crc_run != item.word)
                err_latched = ST_HDR;
            else
            begin
                sum_run = sum_run + ~crc_run;
                crc_run = CRC_INIT;
                pos_in_section++;
            end
        end
        else
        begin
            crc_run = crc_advance(crc_run, item.word);
            pos_in_section++;
        end
    endtask

    task automatic predict_word(input in_t item);
        out_t r;
        // drop words once an error has latched
        if (err_latched == ST_OK)
            absorb_word(item);
        if (item.image_end)
        begin
            if (err_latched == ST_OK && sum_run != sum_target)
                err_latched = ST_SUM;
            r.status     = err_latched;
            r.actual_sum = sum_run;
            if (err_latched == ST_OK || err_latched == ST_SUM)
                r.failing_section = FAIL_W'(sections_done - 1);
            else
                r.failing_section = FAIL_W'(sections_done);
            image_results.push_back(r);
            clear_image_state();
        end
    endtask

    task automatic check_result(input out_t got);
        out_t want;
        results_seen++;
        if (image_results.size() == 0)
            report_mismatch("unexpected result status", got.status, '0);
        else
        begin
            want = image_results.pop_front();
            if (got.status !== want.status)
                report_mismatch("status", got.status, want.status);
            if (got.actual_sum !== want.actual_sum)
                report_mismatch("actual_sum", got.actual_sum, want.actual_sum);
            if (got.failing_section !== want.failing_section)
                report_mismatch("failing_section", got.failing_section, want.failing_section);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_target = '0;
            clear_image_state();
            image_results.delete();
            results_owed = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                sum_target = cfg_data;
            if (out_valid && out_ready)
                check_result(out_data);
            if (in_valid && in_ready)
                predict_word(in_data);
            results_owed = image_results.size();
        end
    end

endmodule

FILE: bench/testbench.sv
// Stimulus and verdict for the section image CRC checker, with the scoreboard beside the block.
`timescale 1ns / 1ps

module testbench;

    import sicc_pkg::*;
    import sicc_bench_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int          PHASE_WORDS = 56;

    typedef enum int {
        IMG_MATCH,
        IMG_MISMATCH,
        IMG_HDR_BAD,
        IMG_DATA_BAD,
        IMG_SHORT,
        IMG_OPEN,
        IMG_NOISE
    } image_kind_e;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    in_t               in_data;
    logic              out_valid;
    logic              out_ready;
    out_t              out_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [WORD_W-1:0] cfg_data;

    int                fail_count;
    int                results_owed;
    int                results_seen;
    int unsigned       cycle_count = 0;

    int                src_idle_pct;
    int                rcv_idle_pct;
    logic              hold_off;
    logic              stall_go;

    in_t               image_words[$];
    logic [WORD_W-1:0] image_crc_sum;
    logic [WORD_W-1:0] sum_goal;
    int                words_sent;
    int                images_sent;

    section_image_crc_checker_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    sicc_image_scoreboard image_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .results_owed (results_owed),
        .results_seen (results_seen)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(negedge clk)
        out_ready = !hold_off && ($urandom_range(0, 99) >= rcv_idle_pct);

    // Long receiver hold-off, counted here so the sender keeps pushing meanwhile
    initial
    begin
        hold_off = 1'b0;
        wait (stall_go);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (400) @(posedge clk);
        hold_off = 1'b0;
    end

    function automatic in_t mk_word(input logic [WORD_W-1:0] w, input logic se, input logic ie);
        in_t r;
        r.word        = w;
        r.section_end = se;
        r.image_end   = ie;
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] nonzero_mask();
        logic [WORD_W-1:0] m;
        m = $urandom;
        if (m == '0)
            m = WORD_W'(1);
        return m;
    endfunction

    task automatic start_image();
        image_words.delete();
        image_crc_sum = '0;
    endtask

    task automatic add_section(input logic [WORD_W-1:0] h0, input logic [WORD_W-1:0] h1,
                               input int ndata, input bit last, input bit hit_goal,
                               input bit bad_hdr, input bit bad_data);
        logic [WORD_W-1:0] run;
        logic [WORD_W-1:0] hcrc;
        logic [WORD_W-1:0] w;
        int                k;
        run  = crc_advance(crc_advance(CRC_INIT, h0), h1);
        hcrc = ~run;
        if (bad_hdr)
            hcrc ^= nonzero_mask();
        else
            image_crc_sum += hcrc;
        image_words.push_back(mk_word(h0, 1'b0, 1'b0));
        image_words.push_back(mk_word(h1, 1'b0, 1'b0));
        image_words.push_back(mk_word(hcrc, 1'b0, 1'b0));
        run = CRC_INIT;
        for (k = 0; k < ndata; k++)
        begin
            w = $urandom;
            // steer the data CRC so the image total lands on the configured sum
            if (hit_goal && k == ndata - 1)
                w = run ^ crc_rewind(~(sum_goal - image_crc_sum));
            run = crc_advance(run, w);
            image_words.push_back(mk_word(w, 1'b0, 1'b0));
        end
        if (bad_data)
            image_words.push_back(mk_word(~run ^ nonzero_mask(), 1'b1, last));
        else
        begin
            image_words.push_back(mk_word(~run, 1'b1, last));
            image_crc_sum += ~run;
        end
    endtask

    task automatic add_short(input bit ends);
        int len;
        int i;
        len = $urandom_range(1, 3);
        for (i = 0; i < len - 1; i++)
            image_words.push_back(mk_word($urandom, 1'b0, 1'b0));
        image_words.push_back(mk_word($urandom, 1'b1, ends));
    endtask

    // Image end inside a section, after a well-formed prefix of it
    task automatic add_open();
        logic [WORD_W-1:0] h0;
        logic [WORD_W-1:0] h1;
        int                npre;
        int                i;
        h0   = $urandom;
        h1   = $urandom;
        npre = $urandom_range(0, 5);
        for (i = 0; i < npre; i++)
        begin
            if (i == 0)
                image_words.push_back(mk_word(h0, 1'b0, 1'b0));
            else if (i == 1)
                image_words.push_back(mk_word(h1, 1'b0, 1'b0));
            else if (i == 2)
                image_words.push_back(mk_word(~crc_advance(crc_advance(CRC_INIT, h0), h1),
                                              1'b0, 1'b0));
            else
                image_words.push_back(mk_word($urandom, 1'b0, 1'b0));
        end
        image_words.push_back(mk_word($urandom, 1'b0, 1'b1));
    endtask

    task automatic add_trailer();
        repeat ($urandom_range(0, 3))
            image_words.push_back(mk_word($urandom, $urandom_range(0, 1), 1'b0));
        image_words.push_back(mk_word($urandom, $urandom_range(0, 1), 1'b1));
    endtask

    function automatic image_kind_e pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return IMG_MATCH;
        else if (r < 55)
            return IMG_MISMATCH;
        else if (r < 65)
            return IMG_HDR_BAD;
        else if (r < 75)
            return IMG_DATA_BAD;
        else if (r < 85)
            return IMG_SHORT;
        else if (r < 93)
            return IMG_OPEN;
        return IMG_NOISE;
    endfunction

    task automatic build_image(input image_kind_e kind, input int nsec);
        int s;
        int bad_at;
        bit ends;
        bit last;
        start_image();
        if (kind == IMG_MATCH || kind == IMG_MISMATCH)
        begin
            for (s = 0; s < nsec; s++)
            begin
                last = (s == nsec - 1);
                add_section($urandom, $urandom, last ? $urandom_range(1, 6) : $urandom_range(0, 6),
                            last, last && kind == IMG_MATCH, 1'b0, 1'b0);
            end
        end
        else
        begin
            bad_at = $urandom_range(0, nsec - 1);
            ends   = (kind == IMG_OPEN || kind == IMG_NOISE) ? 1'b1 : 1'($urandom_range(0, 1));
            for (s = 0; s < bad_at; s++)
                add_section($urandom, $urandom, $urandom_range(0, 6), 1'b0, 1'b0, 1'b0, 1'b0);
            case (kind)
                IMG_HDR_BAD:
                    add_section($urandom, $urandom, $urandom_range(0, 6), ends, 1'b0, 1'b1, 1'b0);
                IMG_DATA_BAD:
                    add_section($urandom, $urandom, $urandom_range(0, 6), ends, 1'b0, 1'b0, 1'b1);
                IMG_SHORT:
                    add_short(ends);
                IMG_OPEN:
                    add_open();
                default:
                    add_trailer();
            endcase
            if (!ends)
                add_trailer();
        end
    endtask

    task automatic push_word(input in_t item);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = item;
        // hold the request until the block takes it
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    task automatic send_image();
        int i;
        for (i = 0; i < image_words.size(); i++)
            push_word(image_words[i]);
        words_sent += image_words.size();
        images_sent++;
    endtask

    task automatic wait_drained();
        in_valid = 1'b0;
        while (results_owed != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_phase(input int src, input int rcv, input logic [WORD_W-1:0] goal);
        src_idle_pct = src;
        rcv_idle_pct = rcv;
        cfg_valid    = 1'b1;
        cfg_data     = goal;
        sum_goal     = goal;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic run_random(input int nwords);
        int stop_at;
        stop_at = words_sent + nwords;
        while (words_sent < stop_at)
        begin
            build_image(pick_kind(), $urandom_range(1, 4));
            send_image();
        end
    endtask

    task automatic send_wide(input int nsec);
        int s;
        start_image();
        for (s = 0; s < nsec; s++)
            add_section($urandom, $urandom, (s == nsec - 1) ? 1 : 0, s == nsec - 1,
                        s == nsec - 1, 1'b0, 1'b0);
        send_image();
    endtask

    task automatic send_long(input int ndata);
        start_image();
        add_section($urandom, $urandom, ndata, 1'b1, 1'b1, 1'b0, 1'b0);
        send_image();
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_ready    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        stall_go     = 1'b0;
        src_idle_pct = 0;
        rcv_idle_pct = 0;
        sum_goal     = '0;
        words_sent   = 0;
        images_sent  = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed images against the reset value of the expected sum
        start_image();
        add_section('0, '1, 0, 1'b1, 1'b0, 1'b0, 1'b0);
        send_image();
        start_image();
        add_section('1, '0, 1, 1'b1, 1'b1, 1'b0, 1'b0);
        send_image();
        start_image();
        add_section($urandom, $urandom, 0, 1'b1, 1'b0, 1'b1, 1'b0);
        send_image();
        start_image();
        add_section($urandom, $urandom, 1, 1'b1, 1'b0, 1'b0, 1'b1);
        send_image();
        start_image();
        image_words.push_back(mk_word('0, 1'b1, 1'b1));
        send_image();
        start_image();
        image_words.push_back(mk_word($urandom, 1'b0, 1'b0));
        image_words.push_back(mk_word($urandom, 1'b0, 1'b0));
        image_words.push_back(mk_word($urandom, 1'b1, 1'b1));
        send_image();
        start_image();
        image_words.push_back(mk_word('1, 1'b0, 1'b1));
        send_image();
        wait_drained();

        set_phase(24, 52, '0);
        run_random(PHASE_WORDS);
        wait_drained();
        set_phase(24, 52, '1);
        run_random(PHASE_WORDS);
        wait_drained();
        set_phase(52, 24, $urandom);
        stall_go = 1'b1;
        run_random(PHASE_WORDS);
        wait_drained();
        set_phase(52, 24, $urandom);
        run_random(PHASE_WORDS);
        wait_drained();
        set_phase(0, 0, $urandom);
        send_wide(MAX_SECTIONS);
        send_wide(MAX_SECTIONS + 1);
        // one word past the longest legal section
        send_long(MAX_SECTION_WORDS - 3);
        run_random(PHASE_WORDS);
        wait_drained();
        set_phase(0, 0, $urandom);
        run_random(PHASE_WORDS);
        wait_drained();
        repeat (10) @(negedge clk);

        $display("Sent %0d words in %0d images; %0d results checked, %0d mismatches",
                 words_sent, images_sent, results_seen, fail_count);
        $display("Covered all status codes, max-size images, a long output stall and idle mixes");
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
